/* design/raic_pkg.sv */
// ---------------------------------------------------------------------------
// raic_pkg: shared types and constants for the RARP/ARP/ICMP frame classifier
// Field widths, protocol codes, result kinds and the captured header record.
// ---------------------------------------------------------------------------
package raic_pkg;

    // Field widths.
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 16;
    localparam int IDX_W   = 11;
    localparam int CFG_IDX_W = 1;

    // Byte counter saturates here.
    localparam logic [IDX_W-1:0] IDX_MAX = 11'd2047;

    // Minimum frame lengths for each check.
    localparam logic [IDX_W-1:0] ETH_HDR_LEN = 11'd14;
    localparam logic [IDX_W-1:0] ARP_MIN_LEN = 11'd42;
    localparam logic [IDX_W-1:0] IP_MIN_LEN  = 11'd34;
    // ICMP type lies at 14 + 4*IHL; echo header needs 8 bytes beyond that.
    localparam logic [IDX_W-1:0] ICMP_HDR_END = 11'd22;

    // Protocol codes.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_ETHERTYPE  = 16'h0806;
    localparam logic [15:0] ETHERTYPE_RARP = 16'h8035;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] RARP_OP_REPLY  = 16'd4;
    localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
    localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_IGNORED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RARP_LEARN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ARP_NOTED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ARP_REPLY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ICMP_ECHO  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STATION_MAC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_RARP = 1'd1;

    // Header fields captured from the byte stream.
    typedef struct packed {
        logic [MAC_W-1:0] dest_addr;
        logic [MAC_W-1:0] src_addr;
        logic [15:0]      ether_kind;
        logic [15:0]      proto_kind;
        logic [15:0]      arp_opcode;
        logic [MAC_W-1:0] arp_target_hw;
        logic [IP_W-1:0]  sender_proto_addr;
        logic [IP_W-1:0]  target_proto_addr;
        logic [IP_W-1:0]  ip_source;
        logic [3:0]       header_words;
        logic [7:0]       ip_protocol;
        logic [7:0]       icmp_type_seen;
        logic             icmp_type_valid;
    } hdr_t;

endpackage

/* design/raic_if.sv */
// ---------------------------------------------------------------------------
// raic_if: valid/ready channels of the frame classifier
// Receive byte channel, classification result channel and register writes.
// ---------------------------------------------------------------------------
interface raic_rx_if;
    import raic_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface raic_res_if;
    import raic_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  frame_kind;
    logic [MAC_W-1:0]   peer_mac;
    logic [IP_W-1:0]    peer_ip;
    logic [IP_W-1:0]    target_ip;
    logic [COUNT_W-1:0] frames_for_me;

    modport source (output valid, output frame_kind, output peer_mac, output peer_ip,
                    output target_ip, output frames_for_me, input ready);
    modport sink   (input valid, input frame_kind, input peer_mac, input peer_ip,
                    input target_ip, input frames_for_me, output ready);
endinterface

interface raic_cfg_if;
    import raic_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [MAC_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/raic_fields.sv */
// ---------------------------------------------------------------------------
// raic_fields: header field capture
// Shifts frame bytes into the header fields at their fixed offsets and
// presents the fields as they stand once the current byte is taken in.
// ---------------------------------------------------------------------------
module raic_fields (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    beat_en,
    input  logic [raic_pkg::IDX_W-1:0] pos,
    input  logic [7:0]              frame_byte,
    input  logic                    frame_last,
    output raic_pkg::hdr_t          hdr_view
);
    import raic_pkg::*;

    hdr_t             hdr_reg;
    hdr_t             hdr_next;
    hdr_t             hdr_hold_next;
    logic [3:0]       words_eff;
    logic [IDX_W-1:0] icmp_pos;

    // Field updates for the byte at position pos.
    always_comb
    begin
        hdr_next = hdr_reg;
        if (pos <= 11'd5)
        begin
            hdr_next.dest_addr = {hdr_reg.dest_addr[MAC_W-9:0], frame_byte};
        end
        else if (pos <= 11'd11)
        begin
            hdr_next.src_addr = {hdr_reg.src_addr[MAC_W-9:0], frame_byte};
        end
        else if (pos <= 11'd13)
        begin
            hdr_next.ether_kind = {hdr_reg.ether_kind[7:0], frame_byte};
        end
        if (pos == 11'd14)
        begin
            hdr_next.header_words = frame_byte[3:0];
        end
        if (pos >= 11'd16 && pos <= 11'd17)
        begin
            hdr_next.proto_kind = {hdr_reg.proto_kind[7:0], frame_byte};
        end
        if (pos >= 11'd20 && pos <= 11'd21)
        begin
            hdr_next.arp_opcode = {hdr_reg.arp_opcode[7:0], frame_byte};
        end
        if (pos == 11'd23)
        begin
            hdr_next.ip_protocol = frame_byte;
        end
        if (pos >= 11'd26 && pos <= 11'd29)
        begin
            hdr_next.ip_source = {hdr_reg.ip_source[IP_W-9:0], frame_byte};
        end
        if (pos >= 11'd28 && pos <= 11'd31)
        begin
            hdr_next.sender_proto_addr = {hdr_reg.sender_proto_addr[IP_W-9:0], frame_byte};
        end
        if (pos >= 11'd32 && pos <= 11'd37)
        begin
            hdr_next.arp_target_hw = {hdr_reg.arp_target_hw[MAC_W-9:0], frame_byte};
        end
        if (pos >= 11'd38 && pos <= 11'd41)
        begin
            hdr_next.target_proto_addr = {hdr_reg.target_proto_addr[IP_W-9:0], frame_byte};
        end

        // The ICMP type byte follows the IP header, whose length may arrive
        // in this very byte.
        words_eff = hdr_next.header_words;
        icmp_pos  = ETH_HDR_LEN + {5'd0, words_eff, 2'b00};
        if (pos >= ETH_HDR_LEN && pos == icmp_pos)
        begin
            hdr_next.icmp_type_seen  = frame_byte;
            hdr_next.icmp_type_valid = 1'b1;
        end
    end

    assign hdr_view = hdr_next;

    // Stored value; the ICMP type valid bit clears at every frame end.
    always_comb
    begin
        hdr_hold_next = hdr_next;
        if (frame_last)
        begin
            hdr_hold_next.icmp_type_valid = 1'b0;
        end
    end

    // Field registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg <= '0;
        end
        else if (beat_en)
        begin
            hdr_reg <= hdr_hold_next;
        end
    end

endmodule

/* design/rarp_arp_icmp_frame_classifier.sv */
// ---------------------------------------------------------------------------
// rarp_arp_icmp_frame_classifier: receive filter for RARP, ARP and ICMP echo
// Classifies each received Ethernet frame at its last byte, learns the
// station IP from RARP replies and counts frames addressed to the station.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Beat contents
//  -------  ---  ---------------------------------------------------------
//  rx       in   frame_byte, frame_last: one frame byte in wire order
//  res      out  frame_kind, peer_mac, peer_ip, target_ip, frames_for_me
//  cfg      in   index, data: register write (0 station MAC, 1 ignore RARP)
//
//  One byte is taken per cycle while no last byte is held back by a stalled
//  result. A byte waits in the input register, and capture and classification
//  run from it into the result register, loaded as the last byte moves on.
//  A stalled result holds back only a following last byte; other bytes keep
//  flowing. Reset clears all state and registers; cfg is always ready.
//
module rarp_arp_icmp_frame_classifier (
    input  logic       clk,
    input  logic       rst_n,
    raic_rx_if.sink    rx,
    raic_res_if.source res,
    raic_cfg_if.sink   cfg
);
    import raic_pkg::*;

    // Configuration registers.
    logic [MAC_W-1:0] station_mac_reg;
    logic             ignore_rarp_reg;

    // Input register.
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;
    logic             advance;

    // Frame state.
    logic [IDX_W-1:0]   byte_index_reg;
    logic [IDX_W-1:0]   frame_len;
    logic [IP_W-1:0]    station_ip_reg;
    logic               station_ip_known_reg;
    logic [COUNT_W-1:0] for_me_count_reg;
    hdr_t               hdr;

    // Classification.
    logic               for_me;
    logic               bcast;
    logic               rarp_match;
    logic               arp_match;
    logic               icmp_match;
    logic [IDX_W-1:0]   icmp_end;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_base;
    logic [COUNT_W-1:0] count_dec;
    logic [COUNT_W-1:0] count_next;
    logic               learn_ip;
    logic [KIND_W-1:0]  kind_next;
    logic [IP_W-1:0]    peer_ip_next;
    logic [IP_W-1:0]    target_ip_next;

    // Result register.
    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    logic [MAC_W-1:0]   out_mac_reg;
    logic [IP_W-1:0]    out_peer_ip_reg;
    logic [IP_W-1:0]    out_target_ip_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_mac_reg <= '0;
            ignore_rarp_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_STATION_MAC: station_mac_reg <= cfg.data;
                CFG_IGNORE_RARP: ignore_rarp_reg <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // A buffered byte moves on unless it ends a frame and the result
    // register is still full.
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || res.ready);
    assign rx.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_byte_reg  <= '0;
            s1_last_reg  <= 1'b0;
        end
        else if (rx.ready)
        begin
            s1_valid_reg <= rx.valid;
            if (rx.valid)
            begin
                s1_byte_reg <= rx.frame_byte;
                s1_last_reg <= rx.frame_last;
            end
        end
    end

    // Header capture.
    raic_fields u_fields (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_en    (advance),
        .pos        (byte_index_reg),
        .frame_byte (s1_byte_reg),
        .frame_last (s1_last_reg),
        .hdr_view   (hdr)
    );

    // Frame length including this byte, saturating.
    assign frame_len = (byte_index_reg == IDX_MAX) ? IDX_MAX : byte_index_reg + 11'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
        end
        else if (advance)
        begin
            byte_index_reg <= s1_last_reg ? '0 : frame_len;
        end
    end

    // Frame checks on the fields as completed by this byte.
    assign for_me   = (hdr.dest_addr == station_mac_reg);
    assign bcast    = (hdr.dest_addr == MAC_BROADCAST);
    assign icmp_end = ICMP_HDR_END + {5'd0, hdr.header_words, 2'b00};

    assign rarp_match = for_me && frame_len >= ARP_MIN_LEN
                        && hdr.ether_kind == ETHERTYPE_RARP
                        && hdr.proto_kind == ETHERTYPE_IPV4
                        && hdr.arp_opcode == RARP_OP_REPLY
                        && hdr.arp_target_hw == station_mac_reg;

    assign arp_match = frame_len >= ARP_MIN_LEN
                       && hdr.ether_kind == ARP_ETHERTYPE
                       && hdr.proto_kind == ETHERTYPE_IPV4
                       && hdr.arp_opcode == ARP_OP_REQUEST
                       && (!station_ip_known_reg
                           || hdr.target_proto_addr == station_ip_reg);

    assign icmp_match = hdr.ether_kind == ETHERTYPE_IPV4
                        && frame_len >= IP_MIN_LEN
                        && hdr.ip_protocol == IP_PROTO_ICMP
                        && icmp_end <= frame_len
                        && hdr.icmp_type_valid
                        && hdr.icmp_type_seen == ICMP_ECHO_REQ;

    // Count: a frame for the station adds one; an ignored RARP reply takes
    // it back; a reported request takes one back unless the count is zero.
    assign count_inc  = for_me ? for_me_count_reg + 16'd1 : for_me_count_reg;
    assign count_base = (rarp_match && ignore_rarp_reg) ? count_inc - 16'd1 : count_inc;
    assign count_dec  = (count_base != '0) ? count_base - 16'd1 : count_base;

    always_comb
    begin
        kind_next      = KIND_IGNORED;
        peer_ip_next   = '0;
        target_ip_next = '0;
        count_next     = count_base;
        learn_ip       = 1'b0;
        priority if (frame_len < ETH_HDR_LEN)
        begin
            count_next = for_me_count_reg;
        end
        else if (rarp_match && !ignore_rarp_reg)
        begin
            kind_next      = KIND_RARP_LEARN;
            target_ip_next = hdr.target_proto_addr;
            count_next     = count_inc;
            learn_ip       = 1'b1;
        end
        else if (bcast)
        begin
            if (arp_match)
            begin
                kind_next      = station_ip_known_reg ? KIND_ARP_REPLY : KIND_ARP_NOTED;
                peer_ip_next   = hdr.sender_proto_addr;
                target_ip_next = hdr.target_proto_addr;
                count_next     = count_dec;
            end
        end
        else if (for_me && icmp_match)
        begin
            kind_next    = KIND_ICMP_ECHO;
            peer_ip_next = hdr.ip_source;
            count_next   = count_dec;
        end
    end

    // Station state changes at frame end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_ip_reg       <= '0;
            station_ip_known_reg <= 1'b0;
            for_me_count_reg     <= '0;
        end
        else if (advance && s1_last_reg)
        begin
            for_me_count_reg <= count_next;
            if (learn_ip)
            begin
                station_ip_reg       <= hdr.target_proto_addr;
                station_ip_known_reg <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            out_kind_reg      <= '0;
            out_mac_reg       <= '0;
            out_peer_ip_reg   <= '0;
            out_target_ip_reg <= '0;
            out_count_reg     <= '0;
        end
        else if (advance && s1_last_reg)
        begin
            out_valid_reg     <= 1'b1;
            out_kind_reg      <= kind_next;
            out_mac_reg       <= (kind_next != KIND_IGNORED) ? hdr.src_addr : '0;
            out_peer_ip_reg   <= peer_ip_next;
            out_target_ip_reg <= target_ip_next;
            out_count_reg     <= count_next;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.frame_kind    = out_kind_reg;
    assign res.peer_mac      = out_mac_reg;
    assign res.peer_ip       = out_peer_ip_reg;
    assign res.target_ip     = out_target_ip_reg;
    assign res.frames_for_me = out_count_reg;

endmodule

/* bench/raic_frame_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raic_frame_checker: predicts and checks the frame classifier's results
// Watches the byte, result and register channels at each rising edge, runs
// its own copy of the classifier state and compares every result beat with
// the oldest prediction, field by field.
// ---------------------------------------------------------------------------
module raic_frame_checker (
    input  logic clk,
    input  logic rst_n,
    raic_rx_if   rx,
    raic_res_if  res,
    raic_cfg_if  cfg,
    output int   fail_count,
    output int   pending
);
    import raic_pkg::*;

    typedef struct {
        logic [KIND_W-1:0]  frame_kind;
        logic [MAC_W-1:0]   peer_mac;
        logic [IP_W-1:0]    peer_ip;
        logic [IP_W-1:0]    target_ip;
        logic [COUNT_W-1:0] frames_for_me;
    } verdict_t;

    // Register copies and classifier state.
    logic [MAC_W-1:0]   own_mac;
    logic               drop_rarp;
    logic [IDX_W-1:0]   bytes_in_frame;
    hdr_t               hdr;
    logic [IP_W-1:0]    own_ip;
    logic               own_ip_known;
    logic [COUNT_W-1:0] for_me;

    verdict_t verdict_q[$];
    verdict_t want;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Classify a finished frame of the given length; updates the learned IP
    // and the for-me count. Returns kind, peer IP and target IP.
    function automatic verdict_t judge_frame(input int len);
        verdict_t v;
        v = '{default: '0};
        if (len < int'(ETH_HDR_LEN))
            return v;
        if (hdr.dest_addr == own_mac) begin
            for_me = for_me + 16'd1;
            if (len >= int'(ARP_MIN_LEN) && hdr.ether_kind == ETHERTYPE_RARP &&
                hdr.proto_kind == ETHERTYPE_IPV4 && hdr.arp_opcode == RARP_OP_REPLY &&
                hdr.arp_target_hw == own_mac) begin
                if (drop_rarp) begin
                    for_me = for_me - 16'd1;
                end
                else begin
                    own_ip = hdr.target_proto_addr;
                    own_ip_known = 1'b1;
                    v.frame_kind = KIND_RARP_LEARN;
                    v.target_ip = hdr.target_proto_addr;
                    return v;
                end
            end
        end
        // Broadcast frames are only ever ARP requests.
        if (hdr.dest_addr == MAC_BROADCAST) begin
            if (len < int'(ARP_MIN_LEN) || hdr.ether_kind != ARP_ETHERTYPE ||
                hdr.proto_kind != ETHERTYPE_IPV4 || hdr.arp_opcode != ARP_OP_REQUEST)
                return v;
            if (own_ip_known && hdr.target_proto_addr != own_ip)
                return v;
            if (for_me != '0)
                for_me = for_me - 16'd1;
            v.peer_ip = hdr.sender_proto_addr;
            v.target_ip = hdr.target_proto_addr;
            v.frame_kind = own_ip_known ? KIND_ARP_REPLY : KIND_ARP_NOTED;
            return v;
        end
        // ICMP echo request addressed to the station.
        if (hdr.dest_addr != own_mac)
            return v;
        if (hdr.ether_kind != ETHERTYPE_IPV4 || len < int'(IP_MIN_LEN) ||
            hdr.ip_protocol != IP_PROTO_ICMP)
            return v;
        if (int'(ICMP_HDR_END) + 4 * int'(hdr.header_words) > len)
            return v;
        if (!hdr.icmp_type_valid || hdr.icmp_type_seen != ICMP_ECHO_REQ)
            return v;
        if (for_me != '0)
            for_me = for_me - 16'd1;
        v.peer_ip = hdr.ip_source;
        v.frame_kind = KIND_ICMP_ECHO;
        return v;
    endfunction

    // Capture one accepted byte at its offset; on the last byte, queue the
    // expected result.
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        int p;
        int len;
        verdict_t v;
        p = int'(bytes_in_frame);
        if (p <= 5)
            hdr.dest_addr = {hdr.dest_addr[39:0], b};
        else if (p <= 11)
            hdr.src_addr = {hdr.src_addr[39:0], b};
        else if (p <= 13)
            hdr.ether_kind = {hdr.ether_kind[7:0], b};
        if (p == 14)
            hdr.header_words = b[3:0];
        if (p == 16 || p == 17)
            hdr.proto_kind = {hdr.proto_kind[7:0], b};
        if (p == 20 || p == 21)
            hdr.arp_opcode = {hdr.arp_opcode[7:0], b};
        if (p == 23)
            hdr.ip_protocol = b;
        if (p >= 26 && p <= 29)
            hdr.ip_source = {hdr.ip_source[23:0], b};
        if (p >= 28 && p <= 31)
            hdr.sender_proto_addr = {hdr.sender_proto_addr[23:0], b};
        if (p >= 32 && p <= 37)
            hdr.arp_target_hw = {hdr.arp_target_hw[39:0], b};
        if (p >= 38 && p <= 41)
            hdr.target_proto_addr = {hdr.target_proto_addr[23:0], b};
        // The ICMP type byte follows the IP header, whatever its length.
        if (p >= 14 && p == 14 + 4 * int'(hdr.header_words)) begin
            hdr.icmp_type_seen = b;
            hdr.icmp_type_valid = 1'b1;
        end
        if (bytes_in_frame != IDX_MAX)
            bytes_in_frame = bytes_in_frame + 11'd1;
        if (!last)
            return;
        len = int'(bytes_in_frame);
        v = judge_frame(len);
        v.peer_mac = (v.frame_kind != KIND_IGNORED) ? hdr.src_addr : '0;
        v.frames_for_me = for_me;
        verdict_q.push_back(v);
        bytes_in_frame = '0;
        hdr.icmp_type_valid = 1'b0;
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            own_mac = '0;
            drop_rarp = 1'b0;
            bytes_in_frame = '0;
            hdr = '0;
            own_ip = '0;
            own_ip_known = 1'b0;
            for_me = '0;
            verdict_q.delete();
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_STATION_MAC: own_mac = cfg.data;
                    CFG_IGNORE_RARP: drop_rarp = cfg.data[0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result beat arrived with nothing expected");
                end
                else begin
                    want = verdict_q.pop_front();
                    if (res.frame_kind !== want.frame_kind)
                        report_mismatch($sformatf("frame_kind got %0d want %0d",
                                                  res.frame_kind, want.frame_kind));
                    if (res.peer_mac !== want.peer_mac)
                        report_mismatch($sformatf("peer_mac got %h want %h",
                                                  res.peer_mac, want.peer_mac));
                    if (res.peer_ip !== want.peer_ip)
                        report_mismatch($sformatf("peer_ip got %h want %h",
                                                  res.peer_ip, want.peer_ip));
                    if (res.target_ip !== want.target_ip)
                        report_mismatch($sformatf("target_ip got %h want %h",
                                                  res.target_ip, want.target_ip));
                    if (res.frames_for_me !== want.frames_for_me)
                        report_mismatch($sformatf("frames_for_me got %0d want %0d",
                                                  res.frames_for_me, want.frames_for_me));
                end
            end
            if (rx.valid && rx.ready)
                predict_byte(rx.frame_byte, rx.frame_last);
        end
        pending = verdict_q.size();
    end

endmodule

/* bench/tb_rarp_arp_icmp_frame_classifier.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rarp_arp_icmp_frame_classifier: stimulus for the frame classifier
// Streams directed and random Ethernet frames (RARP replies, ARP requests,
// ICMP echoes and noise) through several register settings, with random
// gaps and result stalls, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb_rarp_arp_icmp_frame_classifier;
    import raic_pkg::*;

    // Watchdog limit, well above the length of the slowest correct run.
    localparam int RUN_LIMIT = 800000;

    localparam logic [15:0] HTYPE_ETHER  = 16'h0001;
    localparam logic [7:0]  HLEN_ETHER   = 8'd6;
    localparam logic [7:0]  PLEN_IPV4    = 8'd4;
    localparam logic [3:0]  IPV4_VERSION = 4'h4;
    localparam logic [MAC_W-1:0] DIR_MAC = 48'h02_1A_2B_3C_4D_5E;
    localparam logic [IP_W-1:0]  DIR_IP  = 32'h0A01_0203;
    localparam logic [IP_W-1:0]  DIR_OTHER_IP = 32'h0A01_0204;

    typedef enum int {SHAPE_RARP, SHAPE_ARP, SHAPE_ICMP, SHAPE_NOISE} frame_shape_t;

    logic clk = 1'b0;
    logic rst_n;

    raic_rx_if  rx_ch();
    raic_res_if res_ch();
    raic_cfg_if cfg_ch();

    int mismatches;
    int in_flight;
    int cycle_count = 0;

    bit gaps_on;
    bit stalls_on;
    int hold_len;
    logic [MAC_W-1:0] station_mac_cfg;
    logic [IP_W-1:0]  last_rarp_ip;
    logic [7:0]       frame_q[$];

    rarp_arp_icmp_frame_classifier u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    raic_frame_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_ch),
        .res        (res_ch),
        .cfg        (cfg_ch),
        .fail_count (mismatches),
        .pending    (in_flight)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb_rarp_arp_icmp_frame_classifier NOT OK");
            $finish;
        end
    end

    // Result side pacing: random stalls, or one long hold-off on request.
    initial begin : sink_pacing
        int n;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_len != 0) begin
                n = hold_len;
                hold_len = 0;
                res_ch.ready <= 1'b0;
                repeat (n) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    // Start a frame of random bytes.
    function automatic void fill_frame(input int len);
        frame_q = {};
        repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Write a big-endian field of nbytes at byte offset pos.
    function automatic void poke(input int pos, input logic [MAC_W-1:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            frame_q[pos + i] = v[8 * (nbytes - 1 - i) +: 8];
    endfunction

    function automatic void cut_frame(input int len);
        while (frame_q.size() > len)
            void'(frame_q.pop_back());
    endfunction

    // ARP or RARP packet; built full size, then cut to len.
    function automatic void build_arp(input logic [MAC_W-1:0] dest, input logic [15:0] etype,
                                      input logic [15:0] op, input logic [MAC_W-1:0] tha,
                                      input logic [IP_W-1:0] tpa, input int len);
        fill_frame((len > 42) ? len : 42);
        poke(0, dest, 6);
        poke(12, MAC_W'(etype), 2);
        poke(14, MAC_W'(HTYPE_ETHER), 2);
        poke(16, MAC_W'(ETHERTYPE_IPV4), 2);
        poke(18, MAC_W'(HLEN_ETHER), 1);
        poke(19, MAC_W'(PLEN_IPV4), 1);
        poke(20, MAC_W'(op), 2);
        poke(32, tha, 6);
        poke(38, MAC_W'(tpa), 4);
        cut_frame(len);
    endfunction

    // IPv4 packet carrying an ICMP header after an IHL-word IP header.
    function automatic void build_icmp(input logic [MAC_W-1:0] dest, input logic [3:0] ihl,
                                       input logic [7:0] itype, input logic [IP_W-1:0] sip,
                                       input int len);
        int full;
        full = 14 + 4 * int'(ihl) + 1;
        if (full < 30)
            full = 30;
        if (full < len)
            full = len;
        fill_frame(full);
        poke(0, dest, 6);
        poke(12, MAC_W'(ETHERTYPE_IPV4), 2);
        poke(14, MAC_W'({IPV4_VERSION, ihl}), 1);
        poke(23, MAC_W'(IP_PROTO_ICMP), 1);
        poke(26, MAC_W'(sip), 4);
        poke(14 + 4 * int'(ihl), MAC_W'(itype), 1);
        cut_frame(len);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        rx_ch.valid <= 1'b1;
        rx_ch.frame_byte <= b;
        rx_ch.frame_last <= last;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic rx_gap(input int n);
        rx_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_frame();
        int n;
        n = frame_q.size();
        for (int i = 0; i < n; i++) begin
            if (gaps_on && $urandom_range(0, 7) == 0)
                rx_gap($urandom_range(1, 9));
            send_byte(frame_q[i], i == n - 1);
        end
    endtask

    // Stop sending and wait for every expected result, plus the pipeline depth.
    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(negedge clk);
        while (in_flight != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [MAC_W-1:0] mac, input logic ignore_rarp);
        logic [MAC_W-1:0] junk;
        junk = rand_mac();
        drain();
        write_reg(CFG_STATION_MAC, mac);
        // Upper bits of the flag write carry random junk.
        write_reg(CFG_IGNORE_RARP, {junk[MAC_W-1:1], ignore_rarp});
        station_mac_cfg = mac;
    endtask

    // Mostly well-formed frames of each kind, some of them damaged.
    task automatic send_random_frame();
        frame_shape_t shape;
        int pick;
        int len;
        logic [3:0] ihl;
        pick = $urandom_range(0, 99);
        shape = (pick < 30) ? SHAPE_RARP : (pick < 60) ? SHAPE_ARP :
                (pick < 85) ? SHAPE_ICMP : SHAPE_NOISE;
        case (shape)
            SHAPE_RARP: begin
                last_rarp_ip = $urandom;
                build_arp(($urandom_range(0, 99) < 85) ? station_mac_cfg : rand_mac(),
                          ETHERTYPE_RARP,
                          ($urandom_range(0, 99) < 85) ? RARP_OP_REPLY : 16'($urandom_range(0, 5)),
                          ($urandom_range(0, 99) < 85) ? station_mac_cfg : rand_mac(),
                          last_rarp_ip, 42 + $urandom_range(0, 18));
            end
            SHAPE_ARP: begin
                pick = $urandom_range(0, 99);
                build_arp((pick < 85) ? MAC_BROADCAST : (pick < 93) ? station_mac_cfg : rand_mac(),
                          ARP_ETHERTYPE,
                          ($urandom_range(0, 99) < 85) ? ARP_OP_REQUEST : 16'($urandom_range(0, 5)),
                          rand_mac(),
                          ($urandom_range(0, 99) < 70) ? last_rarp_ip : IP_W'($urandom),
                          42 + $urandom_range(0, 18));
            end
            SHAPE_ICMP: begin
                ihl = ($urandom_range(0, 99) < 60) ? 4'd5 : 4'($urandom_range(0, 15));
                len = 14 + 4 * int'(ihl) + 8 + $urandom_range(0, 10);
                if (len < 34)
                    len = 34 + $urandom_range(0, 4);
                build_icmp(($urandom_range(0, 99) < 85) ? station_mac_cfg : rand_mac(), ihl,
                           ($urandom_range(0, 99) < 80) ? ICMP_ECHO_REQ : 8'($urandom),
                           $urandom, len);
            end
            default: begin
                len = $urandom_range(1, 64);
                fill_frame((len > 6) ? len : 6);
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    poke(0, station_mac_cfg, 6);
                else if (pick < 50)
                    poke(0, MAC_BROADCAST, 6);
                cut_frame(len);
            end
        endcase
        // Damage: flip one byte or cut the frame short.
        pick = $urandom_range(0, 99);
        if (pick < 8)
            frame_q[$urandom_range(0, frame_q.size() - 1)] ^= 8'($urandom_range(1, 255));
        else if (pick < 15)
            cut_frame($urandom_range(1, frame_q.size()));
        send_frame();
    endtask

    task automatic run_random(input int byte_budget);
        int sent;
        sent = 0;
        while (sent < byte_budget) begin
            send_random_frame();
            sent += frame_q.size();
        end
    endtask

    // Directed frames: lengths at the edges, every result kind, IHL extremes.
    task automatic run_directed();
        fill_frame(1); frame_q[0] = 8'hFF; send_frame();
        fill_frame(13); poke(0, DIR_MAC, 6); send_frame();
        fill_frame(14); poke(0, DIR_MAC, 6); send_frame();
        // ARP while the IP is still unknown, then a too-short one.
        build_arp(MAC_BROADCAST, ARP_ETHERTYPE, ARP_OP_REQUEST, '0, DIR_IP, 42); send_frame();
        build_arp(MAC_BROADCAST, ARP_ETHERTYPE, ARP_OP_REQUEST, '0, DIR_IP, 41); send_frame();
        // RARP reply with a wrong target MAC, then a good one that teaches the IP.
        build_arp(DIR_MAC, ETHERTYPE_RARP, RARP_OP_REPLY, rand_mac(), DIR_IP, 42); send_frame();
        build_arp(DIR_MAC, ETHERTYPE_RARP, RARP_OP_REPLY, DIR_MAC, DIR_IP, 42); send_frame();
        last_rarp_ip = DIR_IP;
        // ARP for us twice, the second bringing the count to zero, and for someone else.
        build_arp(MAC_BROADCAST, ARP_ETHERTYPE, ARP_OP_REQUEST, '0, DIR_IP, 60); send_frame();
        build_arp(MAC_BROADCAST, ARP_ETHERTYPE, ARP_OP_REQUEST, '0, DIR_IP, 42); send_frame();
        build_arp(MAC_BROADCAST, ARP_ETHERTYPE, ARP_OP_REQUEST, '0, DIR_OTHER_IP, 42);
        send_frame();
        // ICMP echo at exact length and one byte short, then odd header lengths.
        build_icmp(DIR_MAC, 4'd5, ICMP_ECHO_REQ, 32'hC0A8_0001, 42); send_frame();
        build_icmp(DIR_MAC, 4'd5, ICMP_ECHO_REQ, 32'hC0A8_0002, 41); send_frame();
        build_icmp(DIR_MAC, 4'd1, ICMP_ECHO_REQ, 32'hFFFF_FFFF, 34); send_frame();
        build_icmp(DIR_MAC, 4'd15, ICMP_ECHO_REQ, 32'h0000_0000, 82); send_frame();
        build_icmp(DIR_MAC, 4'd15, ICMP_ECHO_REQ, 32'h1234_5678, 81); send_frame();
        build_icmp(DIR_MAC, 4'd0, ICMP_ECHO_REQ, 32'h1234_5678, 40); send_frame();
        build_icmp(DIR_MAC, 4'd5, 8'd0, 32'hC0A8_0003, 50); send_frame();
        // All-zero and all-one frames.
        fill_frame(60);
        foreach (frame_q[i]) frame_q[i] = 8'h00;
        send_frame();
        foreach (frame_q[i]) frame_q[i] = 8'hFF;
        send_frame();
    endtask

    initial begin
        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.frame_byte = '0;
        rx_ch.frame_last = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_STATION_MAC;
        cfg_ch.data = '0;
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        hold_len = 0;
        station_mac_cfg = '0;
        last_rarp_ip = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_config(DIR_MAC, 1'b0);
        run_directed();

        // Long result hold-off while bytes keep coming, so the input backs up.
        set_config(rand_mac(), 1'b1);
        hold_len = 400;
        run_random(180);

        // Zero MAC, with a full pause in the middle.
        set_config('0, 1'b0);
        run_random(90);
        drain();
        run_random(90);

        // Station MAC equal to broadcast, both flag settings.
        set_config(MAC_BROADCAST, 1'b0);
        run_random(180);
        set_config(MAC_BROADCAST, 1'b1);
        run_random(180);

        // Closing stretch at full rate on both sides.
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        set_config(rand_mac(), 1'b0);
        run_random(180);

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("tb_rarp_arp_icmp_frame_classifier OK");
        else
            $display("tb_rarp_arp_icmp_frame_classifier NOT OK");
        $finish;
    end

endmodule
